/* hdl/bre_pkg.sv */
// Shared constants for the base-radix text encoder.
package bre_pkg;

	// Bits in one input byte.
	localparam int BYTE_BITS = 8;
	// Widest symbol and largest symbol count per group.
	localparam int SYM_BITS_MAX = 6;
	localparam int MAX_SYMBOLS = 8;

	// Configuration register indexes.
	localparam logic [7:0] CFG_BITS_PER_SYMBOL   = 8'd0;
	localparam logic [7:0] CFG_BYTES_PER_GROUP   = 8'd1;
	localparam logic [7:0] CFG_SYMBOLS_PER_GROUP = 8'd2;
	localparam logic [7:0] CFG_PAD_CHAR          = 8'd3;

	// Register values after reset.
	localparam logic [2:0] RST_BITS_PER_SYMBOL   = 3'd6;
	localparam logic [2:0] RST_BYTES_PER_GROUP   = 3'd3;
	localparam logic [3:0] RST_SYMBOLS_PER_GROUP = 4'd4;
	localparam logic [7:0] RST_PAD_CHAR          = 8'd61;

	// Input modes.
	localparam logic MODE_ALPHABET = 1'b0;
	localparam logic MODE_DATA     = 1'b1;

endpackage

/* hdl/bre_alpha_mem.sv */
// Alphabet table: one write port and one registered read port.
module bre_alpha_mem #(
	parameter int DEPTH = 64,
	parameter int ADDR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [7:0]        wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [7:0]        rdata
);

	logic [7:0] mem [0:DEPTH-1];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* hdl/base_radix_text_encoder.sv */
// Base-2^k text encoder. An item in alphabet mode writes one table entry; a data byte that
// does not close a group joins the held group. A byte that closes a group (the group is
// full or the byte is marked last) holds the input while the group's symbols
// (symbols_per_group, saturated to 1..8) are issued, one alphabet read per symbol; a stalled
// output can hold the reads. Each symbol passes the read stage, then the output register.
// The next item is taken as soon as the last read of a group has been issued, while symbols
// may still wait at the output. Entries of the alphabet must be written before they are used.
module base_radix_text_encoder
	import bre_pkg::*;
#(
	parameter int ALPHABET_DEPTH = 64,
	parameter int MAX_GROUP_BYTES = 5
) (
	input  logic       clk,
	input  logic       arst_n,
	// Configuration write channel.
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [7:0] cfg_index,
	input  logic [7:0] cfg_data,
	// Input channel.
	input  logic       in_valid,
	output logic       in_stall,
	input  logic       mode,
	input  logic [5:0] alphabet_index,
	input  logic [7:0] alphabet_char,
	input  logic [7:0] data_byte,
	input  logic       last_byte,
	// Output channel.
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] symbol_char,
	output logic       is_pad,
	output logic       last_symbol
);

	localparam int AW = $clog2(ALPHABET_DEPTH);
	localparam int GW = MAX_GROUP_BYTES * BYTE_BITS;
	localparam int HW = $clog2(MAX_GROUP_BYTES + 1);
	localparam int DB_W = HW + 3;
	localparam int CW = (DB_W > 6) ? DB_W : 6;
	localparam logic [HW-1:0] MAX_G = HW'(MAX_GROUP_BYTES);
	localparam logic [6:0] DEPTH_7 = 7'(ALPHABET_DEPTH);

	typedef enum logic {ST_IDLE, ST_EMIT} state_t;

	// Configuration registers.
	logic [2:0] bits_per_symbol_q;
	logic [2:0] bytes_per_group_q;
	logic [3:0] symbols_per_group_q;
	logic [7:0] pad_char_q;

	// Group collection and emission state.
	state_t          state_q;
	logic [GW-1:0]   group_q;
	logic [HW-1:0]   bytes_held_q;
	logic [GW-1:0]   word_q;
	logic [DB_W-1:0] data_bits_q;
	logic [5:0]      pos_q;
	logic [3:0]      sym_left_q;
	logic [2:0]      b_q;
	logic            last_q;

	// Read stage and output register.
	logic       pad_s1, oob_s1, last_s1, valid_s1;
	logic       out_valid_q, is_pad_q, last_symbol_q;
	logic [7:0] symbol_char_q;

	logic            in_accept;
	logic            mem_we, mem_re;
	logic [7:0]      mem_rdata;
	logic [2:0]      b_c;
	logic [HW-1:0]   g_c;
	logic [3:0]      s_c;
	logic [GW-1:0]   group_next;
	logic [HW-1:0]   held_inc, held_c;
	logic [DB_W-1:0] shamt;
	logic            closes;
	logic [5:0]      top6, sym;
	logic            out_free, issue;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bits_per_symbol_q <= RST_BITS_PER_SYMBOL;
			bytes_per_group_q <= RST_BYTES_PER_GROUP;
			symbols_per_group_q <= RST_SYMBOLS_PER_GROUP;
			pad_char_q <= RST_PAD_CHAR;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_BITS_PER_SYMBOL:   bits_per_symbol_q <= cfg_data[2:0];
				CFG_BYTES_PER_GROUP:   bytes_per_group_q <= cfg_data[2:0];
				CFG_SYMBOLS_PER_GROUP: symbols_per_group_q <= cfg_data[3:0];
				CFG_PAD_CHAR:          pad_char_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Register values saturated into their legal ranges.
	always_comb begin
		if (bits_per_symbol_q == 3'd0) begin
			b_c = 3'd1;
		end else if (bits_per_symbol_q > 3'(SYM_BITS_MAX)) begin
			b_c = 3'(SYM_BITS_MAX);
		end else begin
			b_c = bits_per_symbol_q;
		end
		if (bytes_per_group_q == 3'd0) begin
			g_c = HW'(1);
		end else if (int'(bytes_per_group_q) > MAX_GROUP_BYTES) begin
			g_c = MAX_G;
		end else begin
			g_c = HW'(bytes_per_group_q);
		end
		if (symbols_per_group_q == 4'd0) begin
			s_c = 4'd1;
		end else if (symbols_per_group_q > 4'(MAX_SYMBOLS)) begin
			s_c = 4'(MAX_SYMBOLS);
		end else begin
			s_c = symbols_per_group_q;
		end
	end

	assign in_stall = (state_q != ST_IDLE);
	assign in_accept = in_valid && !in_stall;

	assign group_next = (group_q << BYTE_BITS) | GW'(data_byte);
	assign held_inc = bytes_held_q + HW'(1);
	assign held_c = (held_inc > g_c) ? g_c : held_inc;
	assign closes = (held_inc >= g_c) || last_byte;
	// Moves the held bytes to the top of the word; older bytes fall off.
	assign shamt = {MAX_G - held_c, 3'b000};

	assign top6 = word_q[GW-1 -: SYM_BITS_MAX];
	assign sym = top6 >> (3'(SYM_BITS_MAX) - b_q);

	assign out_free = !out_valid_q || !out_stall;
	assign issue = (state_q == ST_EMIT) && (!valid_s1 || out_free);

	assign mem_we = in_accept && (mode == MODE_ALPHABET)
		&& ({1'b0, alphabet_index} < DEPTH_7);
	assign mem_re = issue;

	bre_alpha_mem #(
		.DEPTH(ALPHABET_DEPTH)
	) u_alpha (
		.clk(clk),
		.we(mem_we),
		.waddr(alphabet_index[AW-1:0]),
		.wdata(alphabet_char),
		.re(mem_re),
		.raddr(sym[AW-1:0]),
		.rdata(mem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			group_q <= '0;
			bytes_held_q <= '0;
			sym_left_q <= '0;
			word_q <= '0;
			data_bits_q <= '0;
			pos_q <= '0;
			b_q <= '0;
			last_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_accept && mode == MODE_DATA) begin
						if (closes) begin
							word_q <= group_next << shamt;
							data_bits_q <= {held_c, 3'b000};
							pos_q <= '0;
							sym_left_q <= s_c;
							b_q <= b_c;
							last_q <= last_byte;
							group_q <= '0;
							bytes_held_q <= '0;
							state_q <= ST_EMIT;
						end else begin
							group_q <= group_next;
							bytes_held_q <= held_inc;
						end
					end
				end
				ST_EMIT: begin
					if (issue) begin
						word_q <= word_q << b_q;
						pos_q <= pos_q + 6'(b_q);
						sym_left_q <= sym_left_q - 4'd1;
						if (sym_left_q == 4'd1) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (issue) begin
				valid_s1 <= 1'b1;
			end else if (out_free) begin
				valid_s1 <= 1'b0;
			end
			if (out_free) begin
				out_valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			// A symbol with no bit of a received byte is padding.
			pad_s1 <= CW'(pos_q) >= CW'(data_bits_q);
			oob_s1 <= {1'b0, sym} >= DEPTH_7;
			last_s1 <= last_q && (sym_left_q == 4'd1);
		end
		if (out_free && valid_s1) begin
			symbol_char_q <= pad_s1 ? pad_char_q : (oob_s1 ? 8'd0 : mem_rdata);
			is_pad_q <= pad_s1;
			last_symbol_q <= last_s1;
		end
	end

	assign out_valid = out_valid_q;
	assign symbol_char = symbol_char_q;
	assign is_pad = is_pad_q;
	assign last_symbol = last_symbol_q;

	// The table is never written while a symbol read is being issued.
	a_no_rw_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(mem_we && mem_re))
		else $error("alphabet write during symbol read");

	// The final symbol of a stream is issued only as the group ends.
	a_last_ends_group: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && last_s1 && $past(issue)) |-> (state_q == ST_IDLE))
		else $error("last symbol issued before end of group");

	// A padding symbol always carries the pad character.
	a_pad_char: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && is_pad) |-> (symbol_char == pad_char_q))
		else $error("pad symbol with wrong character");

	// While emitting there is always at least one symbol left.
	a_emit_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT) |-> (sym_left_q != 4'd0))
		else $error("emission with no symbols left");

endmodule

/* dv/tb_base_radix_text_encoder.sv */
// Testbench for the base-radix text encoder: directed and random streams checked against a predictor.
`timescale 1ns / 100ps

module tb_base_radix_text_encoder;
	import bre_pkg::*;

	localparam int ALPHABET_DEPTH  = 64;
	localparam int MAX_GROUP_BYTES = 5;
	localparam logic [7:0] CFG_UNUSED = 8'hFF;
	localparam int HOLD_CYCLES     = 300;
	localparam int STALL_LIMIT     = 3000;
	localparam int IDLE_SETTLE     = 8;
	localparam int RANDOM_PHASES   = 8;
	localparam int ITEMS_PER_PHASE = 24;

	typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_style_t;

	typedef struct {
		logic [7:0] sym_char;
		logic       pad;
		logic       last_sym;
	} symbol_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	logic [7:0] cfg_index = '0;
	logic [7:0] cfg_data = '0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic       mode = MODE_DATA;
	logic [5:0] alphabet_index = '0;
	logic [7:0] alphabet_char = '0;
	logic [7:0] data_byte = '0;
	logic       last_byte = 1'b0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [7:0] symbol_char;
	logic       is_pad;
	logic       last_symbol;

	// Predictor state: alphabet copy, pending group and register settings.
	logic [7:0]  abet [ALPHABET_DEPTH];
	logic [63:0] grp_bits = '0;
	int          grp_held = 0;
	logic [2:0]  cfg_bps = RST_BITS_PER_SYMBOL;
	logic [2:0]  cfg_bpg = RST_BYTES_PER_GROUP;
	logic [3:0]  cfg_spg = RST_SYMBOLS_PER_GROUP;
	logic [7:0]  cfg_pad = RST_PAD_CHAR;

	symbol_t expected_symbols[$];

	int n_errors = 0;
	int n_bytes = 0;
	int n_alpha_writes = 0;
	int n_reg_writes = 0;
	int n_symbols_seen = 0;
	int n_pads = 0;

	stall_style_t stall_style = STALL_NONE;
	bit hold_req = 1'b0;
	bit sender_steady = 1'b1;
	int burst_left = 0;

	base_radix_text_encoder dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.mode          (mode),
		.alphabet_index(alphabet_index),
		.alphabet_char (alphabet_char),
		.data_byte     (data_byte),
		.last_byte     (last_byte),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.symbol_char   (symbol_char),
		.is_pad        (is_pad),
		.last_symbol   (last_symbol)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic int clamp_int(int v, int lo, int hi);
		if (v < lo)
			return lo;
		if (v > hi)
			return hi;
		return v;
	endfunction

	// Adds one data byte to the group and queues the symbols it releases.
	function automatic void predict_symbols(logic [7:0] data, logic last);
		int b, g, s, held, total, pos, idx;
		logic [63:0] word, shifted;
		symbol_t sym;
		b = clamp_int(cfg_bps, 1, SYM_BITS_MAX);
		g = clamp_int(cfg_bpg, 1, MAX_GROUP_BYTES);
		s = clamp_int(cfg_spg, 1, MAX_SYMBOLS);
		grp_bits = {grp_bits[55:0], data};
		held = grp_held + 1;
		if (held < g && !last) begin
			grp_held = held;
			return;
		end
		// A group that shrank under held bytes keeps only its newest bytes.
		if (held > g)
			held = g;
		total = g * BYTE_BITS;
		word = grp_bits & ((64'd1 << total) - 64'd1);
		word = word << (BYTE_BITS * (g - held));
		word = word << (64 - total);
		for (int i = 0; i < s; i++) begin
			pos = i * b;
			sym.pad = (pos >= held * BYTE_BITS);
			idx = 0;
			if (pos < total) begin
				shifted = word << pos;
				idx = int'(shifted >> (64 - b));
			end
			sym.sym_char = sym.pad ? cfg_pad : abet[idx];
			sym.last_sym = last && (i == s - 1);
			if (sym.pad)
				n_pads++;
			expected_symbols.push_back(sym);
		end
		grp_bits = '0;
		grp_held = 0;
	endfunction

	task automatic send_item(logic m, logic [5:0] ai, logic [7:0] ac, logic [7:0] db,
		logic lb);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			gap = sender_steady ? 0 : $urandom_range(0, 6);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		mode <= m;
		alphabet_index <= ai;
		alphabet_char <= ac;
		data_byte <= db;
		last_byte <= lb;
		do @(posedge clk); while (in_stall);
		if (m == MODE_DATA) begin
			predict_symbols(db, lb);
			n_bytes++;
		end else begin
			abet[ai] = ac;
			n_alpha_writes++;
		end
	endtask

	task automatic pause_until_drained();
		in_valid <= 1'b0;
		do @(posedge clk); while (expected_symbols.size() != 0);
	endtask

	// Byte items that close no group give no symbol, so let them settle too.
	task automatic wait_idle();
		pause_until_drained();
		repeat (IDLE_SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(logic [7:0] idx, logic [7:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_BITS_PER_SYMBOL: cfg_bps = val[2:0];
			CFG_BYTES_PER_GROUP: cfg_bpg = val[2:0];
			CFG_SYMBOLS_PER_GROUP: cfg_spg = val[3:0];
			CFG_PAD_CHAR: cfg_pad = val;
			default: ;
		endcase
		n_reg_writes++;
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// Upper bits of the three size register writes are random; the block must ignore them.
	task automatic set_format(logic [2:0] bps, logic [2:0] bpg, logic [3:0] spg,
		logic [7:0] pad);
		write_reg(CFG_BITS_PER_SYMBOL, {5'($urandom), bps});
		write_reg(CFG_BYTES_PER_GROUP, {5'($urandom), bpg});
		write_reg(CFG_SYMBOLS_PER_GROUP, {4'($urandom), spg});
		write_reg(CFG_PAD_CHAR, pad);
	endtask

	task automatic run_format(logic [2:0] bps, logic [2:0] bpg, logic [3:0] spg,
		logic [7:0] pad);
		wait_idle();
		set_format(bps, bpg, spg, pad);
		send_item(MODE_DATA, 6'($urandom), 8'($urandom), 8'($urandom), 1'b0);
		send_item(MODE_DATA, 6'($urandom), 8'($urandom), 8'($urandom), 1'b1);
	endtask

	task automatic test_alphabet_fill();
		sender_steady = 1'b1;
		for (int i = 0; i < ALPHABET_DEPTH; i++)
			send_item(MODE_ALPHABET, 6'(i), 8'($urandom), 8'($urandom), 1'($urandom));
	endtask

	task automatic test_default_format();
		sender_steady = 1'b0;
		stall_style = STALL_LIGHT;
		// Table extremes; the last flag means nothing on an alphabet item.
		send_item(MODE_ALPHABET, 6'd0, 8'h00, 8'hFF, 1'b1);
		send_item(MODE_ALPHABET, 6'd63, 8'hFF, 8'h00, 1'b0);
		send_item(MODE_DATA, 6'h3F, 8'hFF, 8'hFF, 1'b1);
		repeat (3)
			send_item(MODE_DATA, 6'h00, 8'h00, 8'h00, 1'b0);
		send_item(MODE_DATA, 6'h15, 8'hAA, 8'hFF, 1'b0);
		send_item(MODE_DATA, 6'h2A, 8'h55, 8'hFF, 1'b0);
		send_item(MODE_DATA, 6'h00, 8'h00, 8'hFF, 1'b1);
		send_item(MODE_DATA, 6'h00, 8'h00, 8'h12, 1'b0);
		send_item(MODE_DATA, 6'h00, 8'h00, 8'h34, 1'b1);
	endtask

	task automatic test_format_extremes();
		stall_style = STALL_PERIODIC;
		wait_idle();
		write_reg(CFG_UNUSED, 8'($urandom));
		run_format(3'd1, 3'd1, 4'd8, 8'h00);
		// One-byte groups cut into four 6-bit symbols: the tail pads in a full group.
		run_format(3'd6, 3'd1, 4'd4, 8'hFF);
		// Out-of-range settings saturate at both ends.
		run_format(3'd0, 3'd0, 4'd0, 8'h2A);
		run_format(3'd7, 3'd7, 4'd15, 8'h3D);
		run_format(3'd4, 3'd1, 4'd2, 8'h3D);
		run_format(3'd5, 3'd5, 4'd8, 8'h3D);
	endtask

	task automatic test_group_shrink();
		stall_style = STALL_NONE;
		wait_idle();
		set_format(3'd6, 3'd5, 4'd8, 8'h3D);
		repeat (3)
			send_item(MODE_DATA, 6'($urandom), 8'($urandom), 8'($urandom), 1'b0);
		wait_idle();
		set_format(3'd6, 3'd2, 4'd4, 8'h3D);
		send_item(MODE_DATA, 6'($urandom), 8'($urandom), 8'($urandom), 1'b0);
	endtask

	task automatic test_random_streams();
		int unsigned pick;
		logic [2:0] bps, bpg;
		logic [3:0] spg;
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			wait_idle();
			pick = $urandom_range(0, 9);
			if (pick < 3) begin
				bps = 3'd6; bpg = 3'd3; spg = 4'd4;
			end else if (pick < 5) begin
				bps = 3'd5; bpg = 3'd5; spg = 4'd8;
			end else if (pick < 7) begin
				bps = 3'd4; bpg = 3'd1; spg = 4'd2;
			end else begin
				bps = 3'($urandom); bpg = 3'($urandom); spg = 4'($urandom);
			end
			set_format(bps, bpg, spg, 8'($urandom));
			stall_style = stall_style_t'(ph % 4);
			sender_steady = (ph % 3 == 2);
			// Hold the output long enough that the input backs up.
			if (ph == 1) begin
				sender_steady = 1'b1;
				hold_req = 1'b1;
			end
			for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
				if (ph == 3 && k == ITEMS_PER_PHASE / 2)
					pause_until_drained();
				if ($urandom_range(0, 99) < 15)
					send_item(MODE_ALPHABET, 6'($urandom), 8'($urandom), 8'($urandom),
						1'($urandom));
				else
					send_item(MODE_DATA, 6'($urandom), 8'($urandom), 8'($urandom),
						$urandom_range(0, 99) < 15);
			end
		end
	endtask

	// Receiver stall pattern, with one long hold on request.
	initial begin
		int unsigned tick;
		tick = 0;
		forever begin
			@(posedge clk);
			tick++;
			if (hold_req) begin
				hold_req = 1'b0;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				case (stall_style)
					STALL_NONE: out_stall <= 1'b0;
					STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
					STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
					default: out_stall <= ((tick % 5) < 2);
				endcase
			end
		end
	end

	always @(posedge clk) begin
		symbol_t exp_sym;
		if (arst_n && out_valid && !out_stall) begin
			n_symbols_seen++;
			if (expected_symbols.size() == 0) begin
				$error("unexpected symbol: symbol_char %0h is_pad %0b last_symbol %0b",
					symbol_char, is_pad, last_symbol);
				n_errors++;
			end else begin
				exp_sym = expected_symbols.pop_front();
				if (symbol_char !== exp_sym.sym_char) begin
					$error("symbol_char expected %0h got %0h", exp_sym.sym_char, symbol_char);
					n_errors++;
				end
				if (is_pad !== exp_sym.pad) begin
					$error("is_pad expected %0b got %0b", exp_sym.pad, is_pad);
					n_errors++;
				end
				if (last_symbol !== exp_sym.last_sym) begin
					$error("last_symbol expected %0b got %0b", exp_sym.last_sym, last_symbol);
					n_errors++;
				end
			end
		end
	end

	// Ends the run when no channel moves an item for too long.
	initial begin
		int unsigned quiet;
		quiet = 0;
		wait (arst_n === 1'b1);
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("tb_base_radix_text_encoder: errors");
		$finish;
	end

	initial begin
		for (int i = 0; i < ALPHABET_DEPTH; i++)
			abet[i] = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_alphabet_fill();
		test_default_format();
		test_format_extremes();
		test_group_shrink();
		test_random_streams();
		wait_idle();
		$display("Run covered %0d data bytes, %0d alphabet writes and %0d register writes.",
			n_bytes, n_alpha_writes, n_reg_writes);
		$display("%0d symbols came out, %0d of them expected as padding.",
			n_symbols_seen, n_pads);
		if (n_errors == 0 && expected_symbols.size() == 0)
			$display("tb_base_radix_text_encoder: clean");
		else
			$display("tb_base_radix_text_encoder: errors");
		$finish;
	end

endmodule

/* sim.f */
hdl/bre_pkg.sv
hdl/bre_alpha_mem.sv
hdl/base_radix_text_encoder.sv
dv/tb_base_radix_text_encoder.sv
